[rtl/ppr_pkg.sv]
// Shared types and constants of the personalized PageRank engine.
package ppr_pkg;

   localparam int CMD_W    = 2;
   localparam int NODE_W   = 10;
   localparam int STATUS_W = 2;
   localparam int SCORE_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SCORE_W-1:0]  score_type;

   localparam cmd_type CMD_CLEAR = 2'd0;
   localparam cmd_type CMD_ADD   = 2'd1;
   localparam cmd_type CMD_RUN   = 2'd2;
   localparam cmd_type CMD_READ  = 2'd3;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_BAD_NODE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RESTART    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ITERATIONS = 2'd3;

   localparam score_type SCORE_ONE = 32'h8000_0000;

endpackage

[rtl/ppr_ifs.sv]
// Valid/ready channel interfaces for command items and result items.
interface ppr_req_if
   import ppr_pkg::*;
();
   logic     valid;
   logic     ready;
   cmd_type  command;
   node_type source_node;
   node_type target_node;

   modport source (output valid, command, source_node, target_node, input ready);
   modport sink   (input valid, command, source_node, target_node, output ready);
endinterface

interface ppr_rsp_if
   import ppr_pkg::*;
();
   logic       valid;
   logic       ready;
   status_type status;
   score_type  score;

   modport source (output valid, status, score, input ready);
   modport sink   (input valid, status, score, output ready);
endinterface

[rtl/personalized_pagerank_power_iteration.sv]
// Top level of the personalized PageRank engine: sequencer, memories, divider.
//
// Usage: command items enter on req_ch (valid/ready), one result item per
// command leaves on rsp_ch. Configuration registers are written through
// csr_we/csr_index/csr_data while the engine is idle.
// An add with a bad node or a full edge memory is answered from idle, a
// good add stores the edge first; a read fetches the score. A clear
// answers, then holds off intake while it sweeps all MAX_NODES out-degree
// entries. A run loads the restart vector, then in each iteration zeroes
// the new scores, walks every stored edge and scales every node. The edge
// phase runs on the single 32-step restoring divider, one quotient bit per
// cycle.
// One item is in work at a time; req_ch.ready is high only when the engine
// is idle and its result register is empty.
// Reset: a clearing pass over all MAX_NODES entries zeroes out-degrees and
// scores; no item is accepted meanwhile, configuration writes are taken.
// A stalled receiver holds the result in its register and blocks intake
// until it is taken.
module personalized_pagerank_power_iteration
   import ppr_pkg::*;
#(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   ppr_req_if.sink               req_ch,
   ppr_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW  = NW + 1;
   localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ETW = $clog2(MAX_EDGES + 1);
   localparam int DW  = $clog2(MAX_EDGES + 1);
   localparam int QCW = $clog2(SCORE_W);

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_ADD   = 5'd2;
   localparam logic [4:0] S_READ  = 5'd3;
   localparam logic [4:0] S_INIT  = 5'd4;
   localparam logic [4:0] S_ZERO  = 5'd5;
   localparam logic [4:0] S_EFET  = 5'd6;
   localparam logic [4:0] S_EOP   = 5'd7;
   localparam logic [4:0] S_ECHK  = 5'd8;
   localparam logic [4:0] S_EDIV  = 5'd9;
   localparam logic [4:0] S_EWR   = 5'd10;
   localparam logic [4:0] S_SRD   = 5'd11;
   localparam logic [4:0] S_SMUL  = 5'd12;
   localparam logic [4:0] S_SWR   = 5'd13;

   // configuration registers
   logic [10:0]      node_count_ff;
   logic [NODE_W-1:0] restart_ff;
   logic [15:0]      damping_ff;
   logic [9:0]       iter_cnt_ff;

   // sequencer state
   logic [4:0]       state_ff, state_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [ETW-1:0]   edge_ff, edge_in;
   logic [ETW-1:0]   edge_total_ff, edge_total_in;
   logic [9:0]       iter_ff, iter_in;
   logic             clr_all_ff, clr_all_in;
   logic [NW-1:0]    src_ff, src_in, dst_ff, dst_in;
   logic [NW-1:0]    u_ff, u_in, v_ff, v_in;

   // divider and datapath
   logic [SCORE_W-1:0] div_q_ff, div_q_in;
   logic [DW-1:0]      div_r_ff, div_r_in;
   logic [DW-1:0]      div_d_ff, div_d_in;
   logic [QCW-1:0]     div_cnt_ff, div_cnt_in;
   logic [SCORE_W-1:0] acc_ff, acc_in;
   logic [47:0]        prod_ff, prod_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   score_type          rsp_score_ff, rsp_score_in;

   // memories
   logic [2*NW-1:0]    edge_mem [MAX_EDGES];
   logic [DW-1:0]      deg_mem  [MAX_NODES];
   logic [SCORE_W-1:0] old_mem  [MAX_NODES];
   logic [SCORE_W-1:0] new_mem  [MAX_NODES];
   logic [2*NW-1:0]    edge_rd_ff;
   logic [DW-1:0]      deg_rd_ff;
   logic [SCORE_W-1:0] old_rd_ff, new_rd_ff;

   logic               edge_we, deg_we, old_we, new_we;
   logic [EW-1:0]      edge_wa, edge_ra;
   logic [NW-1:0]      deg_wa, deg_ra, old_wa, old_ra, new_wa, new_ra;
   logic [2*NW-1:0]    edge_wd;
   logic [DW-1:0]      deg_wd;
   logic [SCORE_W-1:0] old_wd, new_wd;

   logic [CW-1:0]      n_eff;
   logic               accept, src_ok, dst_ok, idx_last, is_restart;
   logic [DW:0]        div_sh;
   logic               div_ge;
   logic [SCORE_W:0]   edge_sum, scale_sum, rest_term;
   logic [NW-1:0]      eu, ev;
   logic [SCORE_W-1:0] init_val;

   // effective node count: min(node_count, MAX_NODES)
   assign n_eff = (32'(node_count_ff) >= 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                        : CW'(node_count_ff);

   assign req_ch.ready  = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept        = req_ch.valid && req_ch.ready;
   assign src_ok        = 32'(req_ch.source_node) < 32'(n_eff);
   assign dst_ok        = 32'(req_ch.target_node) < 32'(n_eff);
   assign idx_last      = (idx_ff + CW'(1)) == n_eff;
   assign is_restart    = 32'(idx_ff) == 32'(restart_ff);
   assign init_val      = is_restart ? SCORE_ONE : '0;
   assign eu            = edge_rd_ff[2*NW-1:NW];
   assign ev            = edge_rd_ff[NW-1:0];

   // one restoring division step
   assign div_sh = {div_r_ff, div_q_ff[SCORE_W-1]};
   assign div_ge = div_sh >= {1'b0, div_d_ff};

   assign edge_sum  = {1'b0, acc_ff} + {1'b0, div_q_ff};
   assign rest_term = (SCORE_W+1)'((17'h1_0000 - {1'b0, damping_ff})) << 15;
   assign scale_sum = {1'b0, prod_ff[47:16]} + (is_restart ? rest_term : '0);

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.score  = rsp_score_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 11'd1024;
         restart_ff    <= '0;
         damping_ff    <= 16'd55706;
         iter_cnt_ff   <= 10'd300;
      end else if (csr_we) begin
         case (csr_index)
            REG_NODE_COUNT: node_count_ff <= csr_data[10:0];
            REG_RESTART:    restart_ff    <= csr_data[NODE_W-1:0];
            REG_DAMPING:    damping_ff    <= csr_data;
            REG_ITERATIONS: iter_cnt_ff   <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // sequencer and memory port control
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      edge_in       = edge_ff;
      edge_total_in = edge_total_ff;
      iter_in       = iter_ff;
      clr_all_in    = clr_all_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      div_q_in      = div_q_ff;
      div_r_in      = div_r_ff;
      div_d_in      = div_d_ff;
      div_cnt_in    = div_cnt_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_score_in  = rsp_score_ff;

      edge_we = 1'b0;  edge_wa = edge_total_ff[EW-1:0];  edge_wd = {src_ff, dst_ff};
      edge_ra = edge_ff[EW-1:0];
      deg_we  = 1'b0;  deg_wa = idx_ff[NW-1:0];  deg_wd = '0;
      deg_ra  = NW'(req_ch.source_node);
      old_we  = 1'b0;  old_wa = idx_ff[NW-1:0];  old_wd = '0;
      old_ra  = eu;
      new_we  = 1'b0;  new_wa = idx_ff[NW-1:0];  new_wd = '0;
      new_ra  = NW'(req_ch.source_node);

      case (state_ff)
         // sweep out-degrees, and scores after reset
         S_CLR: begin
            deg_we = 1'b1;
            old_we = clr_all_ff;
            new_we = clr_all_ff;
            idx_in = idx_ff + CW'(1);
            if (32'(idx_ff) == 32'(MAX_NODES - 1)) begin
               state_in   = S_IDLE;
               clr_all_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               src_in        = NW'(req_ch.source_node);
               dst_in        = NW'(req_ch.target_node);
               rsp_status_in = ST_OK;
               rsp_score_in  = '0;
               case (req_ch.command)
                  CMD_CLEAR: begin
                     rsp_valid_in  = 1'b1;
                     edge_total_in = '0;
                     idx_in        = '0;
                     state_in      = S_CLR;
                  end
                  CMD_ADD: begin
                     if (!src_ok || !dst_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_NODE;
                     end else if (32'(edge_total_ff) >= 32'(MAX_EDGES)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        state_in = S_ADD;
                     end
                  end
                  CMD_RUN: begin
                     idx_in = '0;
                     if (n_eff == '0) rsp_valid_in = 1'b1;
                     else             state_in     = S_INIT;
                  end
                  CMD_READ: begin
                     if (!src_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_NODE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // store the edge and bump the source out-degree
         S_ADD: begin
            edge_we       = 1'b1;
            deg_we        = 1'b1;
            deg_wa        = src_ff;
            deg_wd        = deg_rd_ff + DW'(1);
            edge_total_in = edge_total_ff + ETW'(1);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_score_in = new_rd_ff;
            state_in     = S_IDLE;
         end
         // load the restart vector
         S_INIT: begin
            old_we = 1'b1;  old_wd = init_val;
            new_we = 1'b1;  new_wd = init_val;
            idx_in = idx_ff + CW'(1);
            if (idx_last) begin
               idx_in  = '0;
               iter_in = '0;
               if (iter_cnt_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_ZERO;
               end
            end
         end
         S_ZERO: begin
            new_we = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (idx_last) begin
               edge_in  = '0;
               state_in = S_EFET;
            end
         end
         // fetch the next edge or move on to scaling
         S_EFET: begin
            if (edge_ff == edge_total_ff) begin
               idx_in   = '0;
               state_in = S_SRD;
            end else begin
               state_in = S_EOP;
            end
         end
         S_EOP: begin
            deg_ra   = eu;
            old_ra   = eu;
            new_ra   = ev;
            u_in     = eu;
            v_in     = ev;
            state_in = S_ECHK;
         end
         // skip stale edges, else start the division
         S_ECHK: begin
            if (32'(u_ff) >= 32'(n_eff) || 32'(v_ff) >= 32'(n_eff) ||
                deg_rd_ff == '0) begin
               edge_in  = edge_ff + ETW'(1);
               state_in = S_EFET;
            end else begin
               div_q_in   = old_rd_ff;
               div_r_in   = '0;
               div_d_in   = deg_rd_ff;
               div_cnt_in = '0;
               acc_in     = new_rd_ff;
               state_in   = S_EDIV;
            end
         end
         S_EDIV: begin
            div_r_in   = div_ge ? DW'(div_sh - {1'b0, div_d_ff}) : div_sh[DW-1:0];
            div_q_in   = {div_q_ff[SCORE_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff + QCW'(1);
            if (div_cnt_ff == QCW'(SCORE_W - 1)) state_in = S_EWR;
         end
         // accumulate the share, saturated at one
         S_EWR: begin
            new_we   = 1'b1;
            new_wa   = v_ff;
            new_wd   = (edge_sum > {1'b0, SCORE_ONE}) ? SCORE_ONE : edge_sum[SCORE_W-1:0];
            edge_in  = edge_ff + ETW'(1);
            state_in = S_EFET;
         end
         S_SRD: begin
            new_ra   = idx_ff[NW-1:0];
            state_in = S_SMUL;
         end
         S_SMUL: begin
            prod_in  = new_rd_ff * damping_ff;
            state_in = S_SWR;
         end
         // damp, add restart mass, saturate, copy to old
         S_SWR: begin
            new_we = 1'b1;
            old_we = 1'b1;
            new_wd = (scale_sum > {1'b0, SCORE_ONE}) ? SCORE_ONE : scale_sum[SCORE_W-1:0];
            old_wd = new_wd;
            idx_in = idx_ff + CW'(1);
            state_in = S_SRD;
            if (idx_last) begin
               idx_in = '0;
               if (iter_ff + 10'd1 == iter_cnt_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  iter_in  = iter_ff + 10'd1;
                  state_in = S_ZERO;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         idx_ff        <= '0;
         clr_all_ff    <= 1'b1;
         edge_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         edge_ff       <= '0;
         iter_ff       <= '0;
         div_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         clr_all_ff    <= clr_all_in;
         edge_total_ff <= edge_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         edge_ff       <= edge_in;
         iter_ff       <= iter_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      div_q_ff      <= div_q_in;
      div_r_ff      <= div_r_in;
      div_d_ff      <= div_d_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_score_ff  <= rsp_score_in;
   end

   // memories with registered reads
   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_wa] <= edge_wd;
      edge_rd_ff <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (deg_we) deg_mem[deg_wa] <= deg_wd;
      deg_rd_ff <= deg_mem[deg_ra];
   end

   always_ff @(posedge clock) begin
      if (old_we) old_mem[old_wa] <= old_wd;
      old_rd_ff <= old_mem[old_ra];
   end

   always_ff @(posedge clock) begin
      if (new_we) new_mem[new_wa] <= new_wd;
      new_rd_ff <= new_mem[new_ra];
   end

   // checks
   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      32'(edge_total_ff) <= 32'(MAX_EDGES))
      else $error("edge count beyond capacity");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EDIV) |-> (div_d_ff != '0))
      else $error("division by zero out-degree");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("second item taken while one is in work");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> (state_ff == S_CLR && !rsp_valid_ff))
      else $error("reset did not start the clearing pass");

endmodule

[tb/personalized_pagerank_power_iteration_tb.sv]
// Self-checking testbench for the personalized PageRank engine.
module personalized_pagerank_power_iteration_tb;
   import ppr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_LIMIT = 1024;
   localparam int EDGE_LIMIT = 8192;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      cmd_type  cmd;
      node_type src;
      node_type dst;
   } command_item_type;

   typedef struct {
      status_type status;
      score_type  score;
   } result_item_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   ppr_req_if req_ch ();
   ppr_rsp_if rsp_ch ();

   personalized_pagerank_power_iteration uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   command_item_type pending_cmds[$];
   result_item_type  expected_results[$];
   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int cycle_count;
   int hold_left;
   bit hold_trigger;
   bit hold_seen;

   // Shadow copy of the engine: registers, graph and scores
   logic [10:0] cfg_nodes;
   logic [9:0]  cfg_restart;
   logic [15:0] cfg_damping;
   logic [9:0]  cfg_iters;
   logic [9:0]  graph_src[EDGE_LIMIT];
   logic [9:0]  graph_dst[EDGE_LIMIT];
   int          graph_edges;
   int unsigned node_degree[NODE_LIMIT];
   logic [31:0] prev_rank[NODE_LIMIT];
   logic [31:0] rank[NODE_LIMIT];

   function automatic int unsigned active_nodes();
      return (cfg_nodes < NODE_LIMIT) ? cfg_nodes : NODE_LIMIT;
   endfunction

   // Power iteration from the restart vector
   function automatic void iterate_ranks();
      int unsigned n;
      int unsigned u;
      int unsigned v;
      logic [63:0] rest;
      logic [63:0] acc;
      n = active_nodes();
      rest = 64'(17'(65536) - cfg_damping) << 15;
      for (int i = 0; i < n; i++) begin
         prev_rank[i] = (i == cfg_restart) ? SCORE_ONE : 32'd0;
         rank[i] = prev_rank[i];
      end
      for (int it = 0; it < cfg_iters; it++) begin
         for (int i = 0; i < n; i++) rank[i] = 32'd0;
         for (int e = 0; e < graph_edges; e++) begin
            u = graph_src[e];
            v = graph_dst[e];
            if (u >= n || v >= n || node_degree[u] == 0) continue;
            acc = 64'(rank[v]) + 64'(prev_rank[u] / node_degree[u]);
            rank[v] = (acc > 64'(SCORE_ONE)) ? SCORE_ONE : acc[31:0];
         end
         for (int i = 0; i < n; i++) begin
            acc = (64'(rank[i]) * 64'(cfg_damping)) >> 16;
            if (i == cfg_restart) acc = acc + rest;
            if (acc > 64'(SCORE_ONE)) acc = 64'(SCORE_ONE);
            rank[i] = acc[31:0];
         end
         for (int i = 0; i < n; i++) prev_rank[i] = rank[i];
      end
   endfunction

   // Apply one command to the shadow state and return its result
   function automatic result_item_type apply_command(command_item_type c);
      result_item_type r;
      int unsigned n;
      n = active_nodes();
      r.status = ST_OK;
      r.score = '0;
      case (c.cmd)
         CMD_CLEAR: begin
            graph_edges = 0;
            for (int i = 0; i < NODE_LIMIT; i++) node_degree[i] = 0;
         end
         CMD_ADD: begin
            if (c.src >= n || c.dst >= n) r.status = ST_BAD_NODE;
            else if (graph_edges >= EDGE_LIMIT) r.status = ST_FULL;
            else begin
               graph_src[graph_edges] = c.src;
               graph_dst[graph_edges] = c.dst;
               graph_edges++;
               node_degree[c.src]++;
            end
         end
         CMD_RUN: iterate_ranks();
         default: begin
            if (c.src >= n) r.status = ST_BAD_NODE;
            else r.score = rank[c.src];
         end
      endcase
      return r;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Driver: offer pending items, predict each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            result_item_type r;
            r = apply_command('{req_ch.command, req_ch.source_node, req_ch.target_node});
            expected_results.insert(expected_results.size(), r);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               command_item_type c;
               c = pending_cmds.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.command     <= c.cmd;
               req_ch.source_node <= c.src;
               req_ch.target_node <= c.dst;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_trigger != hold_seen) begin
         hold_left <= 400;
         hold_seen <= hold_trigger;
      end
   end

   // Monitor: compare each result item with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: status %0d score %h",
                           rsp_ch.status, rsp_ch.score);
            end else begin
               result_item_type x;
               x = expected_results.pop_front();
               if (x.status !== rsp_ch.status || x.score !== rsp_ch.score) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected status %0d score %h, got status %0d score %h",
                              x.status, x.score, rsp_ch.status, rsp_ch.score);
               end
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_NODE_COUNT: cfg_nodes   = value[10:0];
         REG_RESTART:    cfg_restart = value[9:0];
         REG_DAMPING:    cfg_damping = value[15:0];
         default:        cfg_iters   = value[9:0];
      endcase
   endtask

   task automatic setup(int unsigned nodes, int unsigned restart, int unsigned damp,
                        int unsigned iters);
      write_reg(REG_NODE_COUNT, nodes);
      write_reg(REG_RESTART, restart);
      write_reg(REG_DAMPING, damp);
      write_reg(REG_ITERATIONS, iters);
   endtask

   task automatic queue_cmd(cmd_type c, int unsigned s, int unsigned d);
      command_item_type entry;
      entry = '{c, node_type'(s), node_type'(d)};
      pending_cmds.insert(pending_cmds.size(), entry);
   endtask

   // Wait until every item is sent and every result has come back
   task automatic drain();
      do @(negedge clock);
      while (pending_cmds.size() > 0 || req_ch.valid || expected_results.size() > 0);
      repeat (5) @(posedge clock);
   endtask

   // Random item: mostly in-range adds and reads, some noise, rare runs and clears
   task automatic queue_random(int unsigned n, inout int adds_left);
      int unsigned pick;
      int unsigned top;
      top = (n == 0) ? 0 : n - 1;
      pick = $urandom_range(99);
      if (pick < 55 && adds_left > 0) begin
         queue_cmd(CMD_ADD, $urandom_range(top), $urandom_range(top));
         adds_left--;
      end else if (pick < 63) begin
         queue_cmd(CMD_ADD, $urandom_range(1023), $urandom_range(1023));
      end else if (pick < 88) begin
         queue_cmd(CMD_READ, $urandom_range(top), $urandom_range(1023));
      end else if (pick < 94) begin
         queue_cmd(CMD_READ, $urandom_range(1023), $urandom_range(1023));
      end else if (pick < 98) begin
         queue_cmd(CMD_RUN, $urandom_range(1023), $urandom_range(1023));
      end else begin
         queue_cmd(CMD_CLEAR, $urandom_range(1023), $urandom_range(1023));
         adds_left = 30;
      end
   endtask

   initial begin
      int unsigned n;
      int unsigned iters;
      int adds_left;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_CLEAR;
      req_ch.source_node = '0;
      req_ch.target_node = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 21;
      recv_idle_pct = 47;
      mismatch_count = 0;
      cycle_count = 0;
      hold_left = 0;
      hold_trigger = 1'b0;
      hold_seen = 1'b0;
      cfg_nodes = 11'd1024;
      cfg_restart = '0;
      cfg_damping = 16'd55706;
      cfg_iters = 10'd300;
      graph_edges = 0;
      for (int i = 0; i < NODE_LIMIT; i++) begin
         node_degree[i] = 0;
         prev_rank[i] = '0;
         rank[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reads before any run, adds at the node extremes
      queue_cmd(CMD_READ, 0, 0);
      queue_cmd(CMD_READ, 1023, 1023);
      queue_cmd(CMD_ADD, 0, 1023);
      queue_cmd(CMD_ADD, 1023, 0);
      queue_cmd(CMD_ADD, 1023, 1023);
      drain();

      // Small graph with bad-node adds and a bad-node read
      setup(4, 0, 55706, 3);
      queue_cmd(CMD_CLEAR, 0, 0);
      queue_cmd(CMD_ADD, 0, 1);
      queue_cmd(CMD_ADD, 1, 2);
      queue_cmd(CMD_ADD, 2, 0);
      queue_cmd(CMD_ADD, 0, 2);
      queue_cmd(CMD_ADD, 5, 1);
      queue_cmd(CMD_ADD, 1, 9);
      queue_cmd(CMD_RUN, 0, 0);
      for (int i = 0; i < 5; i++) queue_cmd(CMD_READ, i, 0);
      drain();

      // Shrunk node count leaves stale edges; restart node out of range
      setup(2, 3, 65535, 1023);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ, 0, 0);
      queue_cmd(CMD_READ, 1, 0);
      drain();

      // Zero iterations, zero damping
      setup(2, 1, 0, 0);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ, 1, 0);
      drain();

      // No nodes at all
      write_reg(REG_NODE_COUNT, 0);
      queue_cmd(CMD_ADD, 0, 0);
      queue_cmd(CMD_READ, 0, 0);
      queue_cmd(CMD_RUN, 0, 0);
      drain();

      // Node count above the limit clamps to the full node range
      setup(2047, 0, $urandom_range(65535), 1);
      queue_cmd(CMD_READ, 1023, 0);
      queue_cmd(CMD_CLEAR, 0, 0);
      for (int i = 0; i < 16; i++)
         queue_cmd(CMD_ADD, $urandom_range(1023), $urandom_range(1023));
      queue_cmd(CMD_READ, $urandom_range(1023), 0);
      queue_cmd(CMD_CLEAR, 0, 0);
      drain();

      // Restart at the top node of a full-size graph
      setup(1024, 1023, 55706, 1);
      for (int i = 0; i < 5; i++) queue_cmd(CMD_ADD, 1023 - i, 1023 - 2 * i);
      queue_cmd(CMD_RUN, 0, 0);
      queue_cmd(CMD_READ, 1023, 0);
      queue_cmd(CMD_READ, 1021, 0);
      drain();

      // Random phases under three idling patterns
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 47 : 0;
         recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 21 : 0;
         for (int ph = 0; ph < 8; ph++) begin
            n = ($urandom_range(11) == 0) ? 1024 : $urandom_range(16, 1);
            iters = (n == 1024) ? 1 : $urandom_range(4, 1);
            case ($urandom_range(3))
               0: setup(n, $urandom_range(n + 1), 0, iters);
               1: setup(n, $urandom_range(n + 1), 65535, iters);
               default: setup(n, $urandom_range(n + 1), $urandom_range(65535), iters);
            endcase
            queue_cmd(CMD_CLEAR, 0, 0);
            adds_left = 30;
            for (int k = 0; k < 40; k++) begin
               queue_random(n, adds_left);
               if (mode == 0 && ph == 1 && k == 10) begin
                  @(posedge clock);
                  hold_trigger <= ~hold_trigger;
               end
               if (mode == 2 && ph == 3 && k == 24) drain();
            end
            queue_cmd(CMD_RUN, 0, 0);
            for (int k = 0; k < 4; k++) queue_cmd(CMD_READ, $urandom_range(n - 1), 0);
            drain();
         end
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ppr_pkg.sv
rtl/ppr_ifs.sv
rtl/personalized_pagerank_power_iteration.sv
tb/personalized_pagerank_power_iteration_tb.sv
